/* design/svpwm_pkg.sv */
// Shared constants, types and the CORDIC arctangent table for the SVPWM duty pipeline.
// No dependencies; every design module imports this package.
package svpwm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int DUTY_BITS_DEF  = 16;

    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 32;
    localparam int Q_TIME       = 46;

    // Datapath widths: vectoring lane, rotation lane, angle accumulator, scaled index
    localparam int VEC_W = 44;
    localparam int ROT_W = 52;
    localparam int ANG_W = 34;
    localparam int X0_W  = 48;

    localparam logic [14:0] SUPPLY_RESET = 15'd12000;
    localparam logic [15:0] M_CLAMP      = 16'd37814;
    localparam logic signed [31:0] SQ3G_Q30 = 32'sd1129354066;
    localparam logic [31:0] RECIP_SIX    = 32'hAAAA_AAAB;
    localparam logic [29:0] PSI_FULL     = 30'd715827882;

    // Sector codes
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ROT_W-1:0] rot_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t HALF_TURN = {2'b00, 32'h8000_0000};

    // Item entering the rotation stages
    typedef struct packed {
        logic [2:0]             sector;
        logic signed [X0_W-1:0] x0;
        logic [29:0]            phi;
        logic [29:0]            psi;
    } rot_in_t;

    // Item leaving the rotation stages
    typedef struct packed {
        logic [2:0] sector;
        rot_t       t1;
        rot_t       t2;
    } rot_out_t;

    // atan(2^-step) in units of 2^32 per turn
    function automatic ang_t atan_turn(input int step);
        logic [31:0] v;
        case (step)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            default: v = 32'h0;
        endcase
        return {2'b00, v};
    endfunction

endpackage

/* design/svpwm_duty_calculator_top.sv */
// Top level of the SVPWM duty pipeline: supply voltage register and the four stage groups.
// Depends on svpwm_pkg, svpwm_polar, svpwm_sector, svpwm_rotate and svpwm_duty.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------------
//   in      | input     | in_valid / in_stall     | target_q_voltage, target_d_voltage,
//           |           |                         | electrical_angle
//   out     | output    | out_valid / out_stall   | duty_a, duty_b, duty_c, sector_number
//   cfg     | input     | cfg_write_en            | cfg_write_data (supply voltage)
//
// One item per cycle sustained while out_stall is low; the chain holds 32 square root stages,
// 32 divider stages, 28 rotation CORDIC stages and the entry, clamp, sector and duty stages.
// Reset clears all valid bits and loads the supply voltage with 12000; no clearing pass.
// A stall on the output fills empty stages first; in_stall rises only once every stage
// holds an item. Nothing is dropped or repeated under stall.
module svpwm_duty_calculator_top
    import svpwm_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int DUTY_BITS  = DUTY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [15:0]    target_q_voltage,
    input  logic signed [15:0]    target_d_voltage,
    input  logic [ANGLE_BITS-1:0] electrical_angle,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_BITS-1:0]  duty_a,
    output logic [DUTY_BITS-1:0]  duty_b,
    output logic [DUTY_BITS-1:0]  duty_c,
    output logic [2:0]            sector_number,
    input  logic                  cfg_write_en,
    input  logic [14:0]           cfg_write_data
);

    // Supply voltage register; zero acts as one
    logic [14:0] supply_voltage_reg;
    logic [14:0] divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_voltage_reg <= SUPPLY_RESET;
        end
        else if (cfg_write_en)
        begin
            supply_voltage_reg <= cfg_write_data;
        end
    end

    assign divisor = (supply_voltage_reg == 15'd0) ? 15'd1 : supply_voltage_reg;

    logic                  polar_ready, polar_valid;
    logic signed [16:0]    polar_m;
    logic [ANGLE_BITS-1:0] polar_theta;
    logic                  sector_ready, sector_valid;
    rot_in_t               sector_data;
    logic                  rotate_ready, rotate_valid;
    rot_out_t              rotate_data;
    logic                  duty_ready;

    svpwm_polar #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (polar_ready),
        .q_in      (target_q_voltage),
        .d_in      (target_d_voltage),
        .angle_in  (electrical_angle),
        .divisor   (divisor),
        .out_valid (polar_valid),
        .out_ready (sector_ready),
        .m_out     (polar_m),
        .theta_out (polar_theta)
    );

    svpwm_sector #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (polar_valid),
        .in_ready  (sector_ready),
        .m_in      (polar_m),
        .theta_in  (polar_theta),
        .out_valid (sector_valid),
        .out_ready (rotate_ready),
        .out_data  (sector_data)
    );

    svpwm_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sector_valid),
        .in_ready  (rotate_ready),
        .in_data   (sector_data),
        .out_valid (rotate_valid),
        .out_ready (duty_ready),
        .out_data  (rotate_data)
    );

    svpwm_duty #(
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (rotate_valid),
        .in_ready      (duty_ready),
        .in_data       (rotate_data),
        .out_valid     (out_valid),
        .out_ready     (!out_stall),
        .duty_a        (duty_a),
        .duty_b        (duty_b),
        .duty_c        (duty_c),
        .sector_number (sector_number)
    );

    assign in_stall = !polar_ready;

    // Delivered sector is always one of the six
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sector_number >= SECTOR_1 && sector_number <= SECTOR_6))
        else $error("sector out of range");

    // Input backpressure only when the output itself is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // Supply voltage takes the written value
    a_cfg_load: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> (supply_voltage_reg == $past(cfg_write_data)))
        else $error("supply voltage write lost");

endmodule

/* design/svpwm_polar.sv */
// Polar front end: vector length by bitwise square root, modulation index by a
// restoring divider, voltage angle by vectoring CORDIC. Depends on svpwm_pkg.
module svpwm_polar
    import svpwm_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [15:0]       q_in,
    input  logic signed [15:0]       d_in,
    input  logic [ANGLE_BITS-1:0]    angle_in,
    input  logic [14:0]              divisor,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [16:0]       m_out,
    output logic [ANGLE_BITS-1:0]    theta_out
);

    localparam int SQ_LAST   = SQRT_STEPS;
    localparam int DIV_FIRST = SQRT_STEPS + 1;
    localparam int DIV_LAST  = SQRT_STEPS + DIV_STEPS;
    localparam int CLAMP_STG = DIV_LAST + 1;
    localparam int NSTG      = CLAMP_STG + 1;
    localparam int ROUND_STG = CORDIC_STEPS + 1;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [32:0] Z_HALF = 33'd1 << (31 - ANGLE_BITS);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic [NSTG:0]   adv;

    logic [ANGLE_BITS-1:0] theta_reg [0:NSTG-1];
    logic                  dz_reg    [0:NSTG-1];
    logic                  neg_reg   [0:NSTG-1];
    logic [15:0]           aq_reg    [0:SQ_LAST];
    logic [31:0]           r2_reg;
    vec_t                  vx_reg    [0:CORDIC_STEPS];
    vec_t                  vy_reg    [0:CORDIC_STEPS];
    ang_t                  vz_reg    [0:CORDIC_STEPS];
    logic [63:0]           sq_rem_reg [1:SQ_LAST];
    logic [63:0]           sq_res_reg [1:SQ_LAST];
    logic [14:0]           div_rem_reg [DIV_FIRST:DIV_LAST];
    logic [31:0]           div_dq_reg  [DIV_FIRST:DIV_LAST];
    logic signed [16:0]    m_reg;

    // Stage advance: a stage loads when it is empty or its successor loads
    assign adv[NSTG] = out_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign vld_in   = {vld_reg[NSTG-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // Entry stage: squares, magnitude of q, CORDIC start vector
    logic signed [31:0] dd, qq;
    logic [31:0]        r2;
    logic [15:0]        q_abs;
    vec_t               vx0, vy0, vx_init, vy_init;
    ang_t               vz_init;

    assign dd    = d_in * d_in;
    assign qq    = q_in * q_in;
    assign r2    = $unsigned(dd) + $unsigned(qq);
    assign q_abs = q_in[15] ? (~q_in + 16'd1) : q_in;
    assign vx0   = {{(VEC_W-40){d_in[15]}}, d_in, 24'd0};
    assign vy0   = {{(VEC_W-40){q_in[15]}}, q_in, 24'd0};

    // Fold the left half plane onto the right one
    always_comb
    begin
        vx_init = vx0;
        vy_init = vy0;
        vz_init = '0;
        if (d_in[15])
        begin
            vx_init = -vx0;
            vy_init = -vy0;
            vz_init = HALF_TURN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            theta_reg[0] <= angle_in;
            dz_reg[0]    <= (d_in == 16'sd0);
            neg_reg[0]   <= q_in[15];
            aq_reg[0]    <= q_abs;
            r2_reg       <= r2;
            vx_reg[0]    <= vx_init;
            vy_reg[0]    <= vy_init;
            vz_reg[0]    <= vz_init;
        end
    end

    // Carry angle and path flags; advance the angle at the rounding stage
    for (genvar k = 1; k < NSTG; k++) begin : g_carry
        logic [ANGLE_BITS-1:0] theta_in;
        if (k == ROUND_STG) begin : g_round
            logic [32:0]           zsum;
            logic [ANGLE_BITS-1:0] zr;
            assign zsum     = {1'b0, vz_reg[CORDIC_STEPS][31:0]} + Z_HALF;
            assign zr       = zsum[32-ANGLE_BITS +: ANGLE_BITS];
            assign theta_in = dz_reg[k-1] ? theta_reg[k-1] + QUARTER : theta_reg[k-1] + zr;
        end
        else begin : g_pass
            assign theta_in = theta_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                theta_reg[k] <= theta_in;
                dz_reg[k]    <= dz_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
            end
        end
    end

    for (genvar k = 1; k <= SQ_LAST; k++) begin : g_aq
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                aq_reg[k] <= aq_reg[k-1];
            end
        end
    end

    // Vectoring CORDIC, one micro-rotation per stage
    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_vec
        vec_t xs, ys;
        logic y_pos;
        assign xs    = vx_reg[k-1] >>> (k - 1);
        assign ys    = vy_reg[k-1] >>> (k - 1);
        assign y_pos = !vy_reg[k-1][VEC_W-1] && (vy_reg[k-1] != '0);
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                if (y_pos)
                begin
                    vx_reg[k] <= vx_reg[k-1] + ys;
                    vy_reg[k] <= vy_reg[k-1] - xs;
                    vz_reg[k] <= vz_reg[k-1] + atan_turn(k - 1);
                end
                else
                begin
                    vx_reg[k] <= vx_reg[k-1] - ys;
                    vy_reg[k] <= vy_reg[k-1] + xs;
                    vz_reg[k] <= vz_reg[k-1] - atan_turn(k - 1);
                end
            end
        end
    end

    // Square root, one result bit per stage
    for (genvar k = 1; k <= SQ_LAST; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
        logic [63:0] rem_in, res_in, trial;
        if (k == 1) begin : g_first
            assign rem_in = {r2_reg, 32'd0};
            assign res_in = '0;
        end
        else begin : g_next
            assign rem_in = sq_rem_reg[k-1];
            assign res_in = sq_res_reg[k-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                if (rem_in >= trial)
                begin
                    sq_rem_reg[k] <= rem_in - trial;
                    sq_res_reg[k] <= (res_in >> 1) + BIT;
                end
                else
                begin
                    sq_rem_reg[k] <= rem_in;
                    sq_res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    // Restoring divide by the supply voltage, one quotient bit per stage
    for (genvar k = DIV_FIRST; k <= DIV_LAST; k++) begin : g_div
        logic [31:0] dq_in;
        logic [14:0] rem_in;
        logic [15:0] part, diff;
        logic        ge;
        if (k == DIV_FIRST) begin : g_first
            assign dq_in  = dz_reg[k-1] ? {aq_reg[k-1], 16'd0} : sq_res_reg[k-1][31:0];
            assign rem_in = '0;
        end
        else begin : g_next
            assign dq_in  = div_dq_reg[k-1];
            assign rem_in = div_rem_reg[k-1];
        end
        assign part = {rem_in, dq_in[31]};
        assign diff = part - {1'b0, divisor};
        assign ge   = (part >= {1'b0, divisor});
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                div_rem_reg[k] <= ge ? diff[14:0] : part[14:0];
                div_dq_reg[k]  <= {dq_in[30:0], ge};
            end
        end
    end

    // Clamp the index and restore the sign on the q-only path
    logic [31:0]        mm;
    logic [15:0]        mag;
    logic signed [16:0] mag_s, m_next;
    assign mm     = div_dq_reg[DIV_LAST];
    assign mag    = (mm > {16'd0, M_CLAMP}) ? M_CLAMP : mm[15:0];
    assign mag_s  = $signed({1'b0, mag});
    assign m_next = (dz_reg[DIV_LAST] && neg_reg[DIV_LAST]) ? -mag_s : mag_s;

    always_ff @(posedge clk)
    begin
        if (adv[CLAMP_STG])
        begin
            m_reg <= m_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign m_out     = m_reg;
    assign theta_out = theta_reg[NSTG-1];

endmodule

/* design/svpwm_sector.sv */
// Sector search and split of the in-sector angle into the two CORDIC targets.
// Depends on svpwm_pkg (rot_in_t, reciprocal and scale constants).
module svpwm_sector
    import svpwm_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [16:0]    m_in,
    input  logic [ANGLE_BITS-1:0] theta_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rot_in_t               out_data
);

    localparam int NSTG = 2;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic [NSTG:0]   adv;

    assign adv[NSTG] = out_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign vld_in   = {vld_reg[NSTG-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // Stage A: sector, offset inside the sector, scaled start value
    logic [31:0]              th32;
    logic [34:0]              n6;
    logic signed [X0_W:0]     x0p;
    logic [2:0]               sec_a_reg;
    logic [31:0]              n_a_reg;
    logic signed [X0_W-1:0]   x0_a_reg;

    assign th32 = {theta_in, {(32-ANGLE_BITS){1'b0}}};
    assign n6   = {3'b000, th32} * 35'd6;
    assign x0p  = m_in * SQ3G_Q30;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sec_a_reg <= n6[34:32] + 3'd1;
            n_a_reg   <= n6[31:0];
            x0_a_reg  <= x0p[X0_W-1:0];
        end
    end

    // Stage B: divide both offsets by six through the reciprocal
    logic [31:0] n_rev;
    logic [63:0] phi_p, psi_p;
    rot_in_t     out_reg;

    assign n_rev = 32'd0 - n_a_reg;
    assign phi_p = n_a_reg * RECIP_SIX;
    assign psi_p = n_rev * RECIP_SIX;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            out_reg.sector <= sec_a_reg;
            out_reg.x0     <= x0_a_reg;
            out_reg.phi    <= phi_p[63:34];
            out_reg.psi    <= (n_a_reg == 32'd0) ? PSI_FULL : psi_p[63:34];
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

/* design/svpwm_rotate.sv */
// Two-lane rotation CORDIC giving the active vector times t1 and t2.
// Depends on svpwm_pkg (rot_in_t, rot_out_t, atan_turn).
module svpwm_rotate
    import svpwm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rot_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rot_out_t out_data
);

    localparam int NSTG = CORDIC_STEPS;

    typedef struct packed {
        rot_t x;
        rot_t y;
        ang_t z;
    } cordic_t;

    // One micro-rotation toward a zero residual angle
    function automatic cordic_t rot_step(input cordic_t c, input int step);
        cordic_t r;
        rot_t    xs, ys;
        xs = $signed(c.x) >>> step;
        ys = $signed(c.y) >>> step;
        if (!c.z[ANG_W-1])
        begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - atan_turn(step);
        end
        else
        begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + atan_turn(step);
        end
        return r;
    endfunction

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic [NSTG:0]   adv;

    assign adv[NSTG] = out_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign vld_in   = {vld_reg[NSTG-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    cordic_t    t2_lane_reg [0:NSTG-1];
    cordic_t    t1_lane_reg [0:NSTG-1];
    logic [2:0] sec_reg     [0:NSTG-1];

    // Lane start values: scaled index on x, target angle in z
    cordic_t t2_start, t1_start;
    rot_t    x_start;
    assign x_start    = {{(ROT_W-X0_W){in_data.x0[X0_W-1]}}, in_data.x0};
    assign t2_start.x = x_start;
    assign t2_start.y = '0;
    assign t2_start.z = {{(ANG_W-30){1'b0}}, in_data.phi};
    assign t1_start.x = x_start;
    assign t1_start.y = '0;
    assign t1_start.z = {{(ANG_W-30){1'b0}}, in_data.psi};

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        cordic_t t2_in, t1_in;
        logic [2:0] sec_in;
        if (k == 0) begin : g_first
            assign t2_in  = t2_start;
            assign t1_in  = t1_start;
            assign sec_in = in_data.sector;
        end
        else begin : g_next
            assign t2_in  = t2_lane_reg[k-1];
            assign t1_in  = t1_lane_reg[k-1];
            assign sec_in = sec_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                t2_lane_reg[k] <= rot_step(t2_in, k);
                t1_lane_reg[k] <= rot_step(t1_in, k);
                sec_reg[k]     <= sec_in;
            end
        end
    end

    assign out_valid       = vld_reg[NSTG-1];
    assign out_data.sector = sec_reg[NSTG-1];
    assign out_data.t1     = t1_lane_reg[NSTG-1].y;
    assign out_data.t2     = t2_lane_reg[NSTG-1].y;

endmodule

/* design/svpwm_duty.sv */
// Zero time, per-sector duty assignment, rounding and saturation to the output register.
// Depends on svpwm_pkg (rot_out_t, sector codes, time format).
module svpwm_duty
    import svpwm_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rot_out_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DUTY_BITS-1:0] duty_a,
    output logic [DUTY_BITS-1:0] duty_b,
    output logic [DUTY_BITS-1:0] duty_c,
    output logic [2:0]           sector_number
);

    localparam int NSTG = 3;
    localparam rot_t T_ONE = {{(ROT_W-Q_TIME-1){1'b0}}, 1'b1, {Q_TIME{1'b0}}};
    localparam logic [ROT_W:0] RND = (ROT_W+1)'(1) << (Q_TIME - 1 - DUTY_BITS);

    // Round a time to duty resolution; negative gives zero, overflow saturates
    function automatic logic [DUTY_BITS-1:0] to_duty(input rot_t t);
        logic [ROT_W:0]       u;
        logic [ROT_W:0]       sh;
        logic [DUTY_BITS-1:0] r;
        u  = {1'b0, t} + RND;
        sh = u >> (Q_TIME - DUTY_BITS);
        if (t[ROT_W-1])
        begin
            r = '0;
        end
        else if (sh[ROT_W:DUTY_BITS] != '0)
        begin
            r = '1;
        end
        else
        begin
            r = sh[DUTY_BITS-1:0];
        end
        return r;
    endfunction

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic [NSTG:0]   adv;

    assign adv[NSTG] = out_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign vld_in   = {vld_reg[NSTG-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // Stage A: half zero time and the sum of both active times
    rot_t       t0_diff;
    rot_t       h_a_reg, t1_a_reg, t2_a_reg, t12_a_reg;
    logic [2:0] sec_a_reg;
    assign t0_diff = T_ONE - in_data.t1 - in_data.t2;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            h_a_reg   <= t0_diff >>> 1;
            t1_a_reg  <= in_data.t1;
            t2_a_reg  <= in_data.t2;
            t12_a_reg <= in_data.t1 + in_data.t2;
            sec_a_reg <= in_data.sector;
        end
    end

    // Stage B: assign phase times by sector
    rot_t       ta_next, tb_next, tc_next;
    rot_t       ta_b_reg, tb_b_reg, tc_b_reg;
    logic [2:0] sec_b_reg;

    always_comb
    begin
        unique case (sec_a_reg)
            SECTOR_1:
            begin
                ta_next = t12_a_reg + h_a_reg;
                tb_next = t2_a_reg + h_a_reg;
                tc_next = h_a_reg;
            end
            SECTOR_2:
            begin
                ta_next = t1_a_reg + h_a_reg;
                tb_next = t12_a_reg + h_a_reg;
                tc_next = h_a_reg;
            end
            SECTOR_3:
            begin
                ta_next = h_a_reg;
                tb_next = t12_a_reg + h_a_reg;
                tc_next = t2_a_reg + h_a_reg;
            end
            SECTOR_4:
            begin
                ta_next = h_a_reg;
                tb_next = t1_a_reg + h_a_reg;
                tc_next = t12_a_reg + h_a_reg;
            end
            SECTOR_5:
            begin
                ta_next = t2_a_reg + h_a_reg;
                tb_next = h_a_reg;
                tc_next = t12_a_reg + h_a_reg;
            end
            default:
            begin
                ta_next = t12_a_reg + h_a_reg;
                tb_next = h_a_reg;
                tc_next = t1_a_reg + h_a_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            ta_b_reg  <= ta_next;
            tb_b_reg  <= tb_next;
            tc_b_reg  <= tc_next;
            sec_b_reg <= sec_a_reg;
        end
    end

    // Stage C: output register
    logic [DUTY_BITS-1:0] duty_a_reg, duty_b_reg, duty_c_reg;
    logic [2:0]           sector_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            duty_a_reg <= to_duty(ta_b_reg);
            duty_b_reg <= to_duty(tb_b_reg);
            duty_c_reg <= to_duty(tc_b_reg);
            sector_reg <= sec_b_reg;
        end
    end

    assign out_valid     = vld_reg[NSTG-1];
    assign duty_a        = duty_a_reg;
    assign duty_b        = duty_b_reg;
    assign duty_c        = duty_c_reg;
    assign sector_number = sector_reg;

endmodule

/* tb/tb_svpwm_duty_calculator_top.sv */
// Testbench for svpwm_duty_calculator_top: random and directed items checked against
// an in-bench predictor of the SVPWM duty calculation. Depends on svpwm_pkg and the RTL.
`timescale 1ns / 1ps
module tb_svpwm_duty_calculator_top;
    import svpwm_pkg::*;

    typedef struct {
        logic signed [15:0] q_volt;
        logic signed [15:0] d_volt;
        logic [15:0]        angle;
    } volt_item_t;

    typedef struct {
        logic [15:0] da;
        logic [15:0] db;
        logic [15:0] dc;
        logic [2:0]  sector;
    } duty_item_t;

    localparam int STEPS = 28;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 120;

    // atan(2^-i) in units of 2^32 per turn
    localparam longint ATAN_TAB [STEPS] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic signed [15:0] target_q_voltage;
    logic signed [15:0] target_d_voltage;
    logic [15:0] electrical_angle;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector_number;
    logic        cfg_write_en;
    logic [14:0] cfg_write_data;

    volt_item_t  pending_items[$];
    duty_item_t  expected_duties[$];
    logic [14:0] bus_voltage;
    int          error_count;
    int          sender_idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    svpwm_duty_calculator_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .target_q_voltage (target_q_voltage),
        .target_d_voltage (target_d_voltage),
        .electrical_angle (electrical_angle),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .duty_a           (duty_a),
        .duty_b           (duty_b),
        .duty_c           (duty_c),
        .sector_number    (sector_number),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data)
    );

    // Clock generation
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned val);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > val)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (val >= res + bitv)
            begin
                val = val - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC: atan2(y, x) in units of 2^32 per turn
    function automatic longint unsigned vector_angle(input longint x, input longint y);
        longint z;
        longint nx;
        longint ny;
        z = 0;
        x = x * 16777216;
        y = y * 16777216;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = longint'(1) <<< 31;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ATAN_TAB[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return longint'(z) & 64'hFFFF_FFFF;
    endfunction

    // Rotation CORDIC: y component of (x0, 0) turned by ang
    function automatic longint rotate_sine(input longint x0, input longint ang);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        x = x0;
        y = 0;
        z = ang;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ATAN_TAB[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return y;
    endfunction

    function automatic logic [15:0] time_to_duty(input longint t);
        longint unsigned u;
        if (t < 0)
            return 16'd0;
        u = (longint'(t) + (64'd1 << 29)) >> 30;
        return (u > 64'hFFFF) ? 16'hFFFF : u[15:0];
    endfunction

    // Predict duties and sector for one voltage item
    function automatic duty_item_t predict_duties(input volt_item_t it);
        longint q;
        longint d;
        longint m;
        longint x0;
        longint t1;
        longint t2;
        longint h;
        longint ta;
        longint tb;
        longint tc;
        longint unsigned theta;
        longint unsigned v;
        longint unsigned mag;
        longint unsigned z;
        longint unsigned s;
        longint unsigned n;
        duty_item_t r;
        q = it.q_volt;
        d = it.d_volt;
        theta = it.angle;
        v = (bus_voltage == 0) ? 1 : bus_voltage;
        if (d != 0)
        begin
            mag = int_sqrt(longint'(d * d + q * q) << 32) / v;
            z = (vector_angle(d, q) + (64'd1 << 15)) >> 16;
            m = (mag > M_CLAMP) ? longint'(M_CLAMP) : longint'(mag);
            theta = (theta + z) & 64'hFFFF;
        end
        else
        begin
            mag = (longint'(q < 0 ? -q : q) << 16) / v;
            if (mag > M_CLAMP)
                mag = M_CLAMP;
            m = (q < 0) ? -longint'(mag) : longint'(mag);
            theta = (theta + 64'h4000) & 64'hFFFF;
        end
        s = ((theta * 6) >> 16) + 1;
        n = (theta << 16) * 6 - ((s - 1) << 32);
        x0 = m * longint'(SQ3G_Q30);
        t2 = rotate_sine(x0, longint'(n / 6));
        t1 = rotate_sine(x0, longint'(((64'd1 << 32) - n) / 6));
        h = ((longint'(1) <<< Q_TIME) - t1 - t2) >>> 1;
        case (s[2:0])
            SECTOR_1: begin ta = t1 + t2 + h; tb = t2 + h;      tc = h;           end
            SECTOR_2: begin ta = t1 + h;      tb = t1 + t2 + h; tc = h;           end
            SECTOR_3: begin ta = h;           tb = t1 + t2 + h; tc = t2 + h;      end
            SECTOR_4: begin ta = h;           tb = t1 + h;      tc = t1 + t2 + h; end
            SECTOR_5: begin ta = t2 + h;      tb = h;           tc = t1 + t2 + h; end
            default:  begin ta = t1 + t2 + h; tb = h;           tc = t1 + h;      end
        endcase
        r.da = time_to_duty(ta);
        r.db = time_to_duty(tb);
        r.dc = time_to_duty(tc);
        r.sector = s[2:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic queue_item(input int q, input int d, input int a);
        volt_item_t it;
        it.q_volt = q[15:0];
        it.d_volt = d[15:0];
        it.angle = a[15:0];
        pending_items.push_back(it);
    endtask

    // Random mix: moderate voltages near the bus, full-range items and q-only items
    task automatic queue_random(input int count);
        int span;
        int sel;
        for (int i = 0; i < count; i++)
        begin
            span = (bus_voltage < 2) ? 4 : int'(bus_voltage);
            if (span > 32767)
                span = 32767;
            sel = $urandom_range(9);
            if (sel < 3)
                queue_item($urandom, $urandom, $urandom);
            else if (sel < 6)
                queue_item($urandom_range(2 * span) - span, 0, $urandom);
            else
                queue_item($urandom_range(span) - span / 2, $urandom_range(span) - span / 2,
                           $urandom);
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_duties.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_supply(input logic [14:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= val;
        bus_voltage = val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Driver: advance to the next item on acceptance, with random gaps
    always @(posedge clk)
    begin
        volt_item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_duties.push_back(predict_duties('{target_q_voltage,
                                                           target_d_voltage,
                                                           electrical_angle}));
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    it = pending_items.pop_front();
                    in_valid <= 1'b1;
                    target_q_voltage <= it.q_volt;
                    target_d_voltage <= it.d_volt;
                    electrical_angle <= it.angle;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        duty_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_duties.size() == 0)
                report_mismatch("unexpected result", sector_number, 0);
            else
            begin
                e = expected_duties.pop_front();
                if (duty_a !== e.da)
                    report_mismatch("duty_a", duty_a, e.da);
                if (duty_b !== e.db)
                    report_mismatch("duty_b", duty_b, e.db);
                if (duty_c !== e.dc)
                    report_mismatch("duty_c", duty_c, e.dc);
                if (sector_number !== e.sector)
                    report_mismatch("sector_number", sector_number, e.sector);
            end
        end
    end

    // Watchdog: count cycles without progress while work is pending
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (pending_items.size() == 0 && expected_duties.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus phases
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        target_q_voltage = '0;
        target_d_voltage = '0;
        electrical_angle = '0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        bus_voltage = SUPPLY_RESET;
        error_count = 0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, q-only path both signs, sector boundaries
        queue_item(0, 0, 0);
        queue_item(32767, 0, 0);
        queue_item(-32768, 0, 65535);
        queue_item(3000, 0, 10922);
        queue_item(-3000, 0, 10923);
        queue_item(-500, 0, 21845);
        queue_item(0, 32767, 32768);
        queue_item(0, -32768, 43690);
        queue_item(-32768, 32767, 43691);
        queue_item(32767, -32768, 54613);
        queue_item(-32768, -32768, 54614);
        queue_item(1, -1, 1);
        queue_item(-1, 1, 65535);
        queue_item(4000, 2000, 0);
        queue_item(-4000, 2000, 16384);
        queue_item(2000, -4000, 49152);
        queue_item(0, 1, 32767);
        queue_item(100, 0, 12345);
        queue_item(-100, 0, 54321);
        queue_item(6000, 6000, 65000);
        wait_idle();

        // No idling, reset bus voltage
        queue_random(150);
        wait_idle();

        // Minimum bus voltage, sender mostly idle
        write_supply(15'd1);
        sender_idle_pct = 82;
        queue_random(80);
        wait_idle();

        // Maximum bus voltage, receiver mostly stalled
        write_supply(15'd32767);
        sender_idle_pct = 0;
        stall_pct = 82;
        queue_random(100);
        wait_idle();

        // Zero bus voltage counts as one; both sides idle
        write_supply(15'd0);
        sender_idle_pct = 30;
        stall_pct = 30;
        queue_random(80);
        wait_idle();

        // Random bus voltage; hold the sender until all results are back midway
        write_supply(15'($urandom_range(32767, 1)));
        sender_idle_pct = 0;
        stall_pct = 0;
        queue_random(90);
        while (pending_items.size() != 0 || expected_duties.size() != 0)
            @(posedge clk);
        stall_pct = 30;
        queue_random(90);
        wait_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
